### src/greedy_box_suppression_top_assert.svh
// ----------------------------------------------------------------------------
// greedy_box_suppression_top_assert.svh
// assertion macros for the box suppression block, clocked on aclk and
// disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_TOP_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_TOP_ASSERT_SVH

// same-cycle implication
`define GBS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("gbs assertion failed");

// next-cycle implication
`define GBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("gbs assertion failed");

`endif

### src/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// shared widths, constants and types of the greedy box suppression block
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    localparam int COORD_W      = 16;
    localparam int SIZE_W       = 15;
    localparam int INDEX_W      = 16;
    localparam int TOTAL_W      = 9;
    localparam int THR_W        = 8;
    localparam int BOX_W        = 64;
    localparam int AREA_W       = 2 * SIZE_W;
    localparam int UNION_W      = AREA_W + 1;
    localparam int PROD_W       = UNION_W + THR_W;
    localparam int MAX_KEPT_DEF = 256;

    localparam logic [THR_W-1:0] THR_RESET = 8'd115;

    // status of the overlap test pipeline toward the sequencer
    typedef struct packed {
        logic hit;
        logic busy;
    } iou_status_t;

    // stored layout: x in [15:0], y in [31:16], w in [46:32], h in [62:48]
    function automatic logic [BOX_W-1:0] pack_box(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [SIZE_W-1:0]  w,
        input logic [SIZE_W-1:0]  h
    );
        pack_box = {1'b0, h, 1'b0, w, y, x};
    endfunction

endpackage

`default_nettype wire

### src/greedy_box_suppression_top.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_top
// greedy non-maximum suppression by intersection-over-union over a kept list
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  s_*       start_of_set, box_x/y/w/h               in, valid/ready
//  m_*       keep, item_index, kept_total, list_full out, valid/ready
//  cfg_*     iou_threshold write, no handshake       in
//
//  stored boxes are read from the kept ram one per cycle into a five-stage
//  overlap test; with k boxes to scan the result loads once all k are tested
//  (no test runs for an empty list), or as soon as a suppressing box at entry j hits
//  s_ready returns with the result load; a stalled m_ready holds the next box
//  in work until the result frees
//  reset is synchronous; the kept ram needs no clearing, only entries below
//  the kept count are read
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression_top #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gbs_pkg::THR_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_start_of_set,
    input  wire logic [gbs_pkg::COORD_W-1:0]   s_box_x,
    input  wire logic [gbs_pkg::COORD_W-1:0]   s_box_y,
    input  wire logic [gbs_pkg::SIZE_W-1:0]    s_box_w,
    input  wire logic [gbs_pkg::SIZE_W-1:0]    s_box_h,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_keep,
    output logic [gbs_pkg::INDEX_W-1:0]        m_item_index,
    output logic [gbs_pkg::TOTAL_W-1:0]        m_kept_total,
    output logic                               m_list_full
);

    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int TW     = gbs_pkg::TOTAL_W;
    localparam int IW     = gbs_pkg::INDEX_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_KEPT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [gbs_pkg::THR_W-1:0]     thr_reg;
    logic [CNT_W-1:0]              kept_count_reg, kept_count_next;
    logic [CNT_W-1:0]              issue_cnt_reg, issue_cnt_next;
    logic [IW-1:0]                 box_counter_reg, box_counter_next;
    logic [IW-1:0]                 res_index_reg, res_index_next;
    logic                          res_keep_reg, res_keep_next;
    logic                          res_full_reg, res_full_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_keep_reg;
    logic [IW-1:0]                 m_index_reg;
    logic [TW-1:0]                 m_total_reg;
    logic                          m_full_reg;
    logic [gbs_pkg::COORD_W-1:0]   cand_x_reg, cand_y_reg;
    logic [gbs_pkg::SIZE_W-1:0]    cand_w_reg, cand_h_reg;

    logic                          in_xfer;
    logic                          rd_en;
    logic                          ram_we;
    logic                          flush;
    logic                          out_load;
    logic [gbs_pkg::BOX_W-1:0]     ram_rdata;
    logic [IW-1:0]                 start_index;
    gbs_pkg::iou_status_t          test_status;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;
    assign start_index = s_start_of_set ? '0 : box_counter_reg;

    always_comb begin
        state_next       = state_reg;
        kept_count_next  = kept_count_reg;
        issue_cnt_next   = issue_cnt_reg;
        box_counter_next = box_counter_reg;
        res_index_next   = res_index_reg;
        res_keep_next    = res_keep_reg;
        res_full_next    = res_full_reg;
        rd_en            = 1'b0;
        ram_we           = 1'b0;
        flush            = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_start_of_set) begin
                        kept_count_next = '0;
                    end
                    res_index_next   = start_index;
                    box_counter_next = start_index + IW'(1);
                    issue_cnt_next   = '0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (test_status.hit) begin
                    // suppressed: drop the tests still in flight
                    flush         = 1'b1;
                    res_keep_next = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = ST_OUT;
                end else if (issue_cnt_reg < kept_count_reg) begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end else if (!test_status.busy) begin
                    res_keep_next = 1'b1;
                    if (kept_count_reg < FULL_COUNT) begin
                        ram_we          = 1'b1;
                        kept_count_next = kept_count_reg + CNT_W'(1);
                        res_full_next   = 1'b0;
                    end else begin
                        res_full_next   = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            thr_reg         <= gbs_pkg::THR_RESET;
            kept_count_reg  <= '0;
            issue_cnt_reg   <= '0;
            box_counter_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            kept_count_reg  <= kept_count_next;
            issue_cnt_reg   <= issue_cnt_next;
            box_counter_reg <= box_counter_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_index_reg <= res_index_next;
        res_keep_reg  <= res_keep_next;
        res_full_reg  <= res_full_next;
        if (in_xfer) begin
            cand_x_reg <= s_box_x;
            cand_y_reg <= s_box_y;
            cand_w_reg <= s_box_w;
            cand_h_reg <= s_box_h;
        end
        if (out_load) begin
            m_keep_reg  <= res_keep_reg;
            m_index_reg <= res_index_reg;
            m_total_reg <= TW'(kept_count_reg);
            m_full_reg  <= res_full_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_keep       = m_keep_reg;
    assign m_item_index = m_index_reg;
    assign m_kept_total = m_total_reg;
    assign m_list_full  = m_full_reg;

    gbs_ram #(
        .DATA_W (gbs_pkg::BOX_W),
        .DEPTH  (MAX_KEPT)
    ) u_kept_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (kept_count_reg[ADDR_W-1:0]),
        .wdata (gbs_pkg::pack_box(cand_x_reg, cand_y_reg, cand_w_reg, cand_h_reg)),
        .re    (rd_en),
        .raddr (issue_cnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    gbs_iou_pipe u_iou_pipe (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .issue         (rd_en),
        .flush         (flush),
        .stored_box    (ram_rdata),
        .cand_x        (cand_x_reg),
        .cand_y        (cand_y_reg),
        .cand_w        (cand_w_reg),
        .cand_h        (cand_h_reg),
        .iou_threshold (thr_reg),
        .status        (test_status)
    );

`include "greedy_box_suppression_top_assert.svh"

    `GBS_ASSERT_SAME(a_count_bound, 1'b1, kept_count_reg <= FULL_COUNT)
    `GBS_ASSERT_SAME(a_store_room, ram_we, kept_count_reg < FULL_COUNT)
    `GBS_ASSERT_SAME(a_read_range, rd_en, issue_cnt_reg < kept_count_reg)
    `GBS_ASSERT_SAME(a_full_keeps, m_valid && m_list_full, m_keep)
    `GBS_ASSERT_NEXT(a_busy_after, in_xfer, !s_ready)

endmodule

`default_nettype wire

### src/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ram #(
    parameter int   DATA_W = 64,
    parameter int   DEPTH  = 256,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/gbs_iou_pipe.sv
// ----------------------------------------------------------------------------
// gbs_iou_pipe
// one overlap test per cycle: candidate box against one stored box, in
// five register stages, reports a hit when inter*256 > thr*union
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_iou_pipe (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              issue,
    input  wire logic                              flush,
    input  wire logic [gbs_pkg::BOX_W-1:0]         stored_box,
    input  wire logic [gbs_pkg::COORD_W-1:0]       cand_x,
    input  wire logic [gbs_pkg::COORD_W-1:0]       cand_y,
    input  wire logic [gbs_pkg::SIZE_W-1:0]        cand_w,
    input  wire logic [gbs_pkg::SIZE_W-1:0]        cand_h,
    input  wire logic [gbs_pkg::THR_W-1:0]         iou_threshold,
    output gbs_pkg::iou_status_t                   status
);

    localparam int SW = gbs_pkg::SIZE_W;
    localparam int CW = gbs_pkg::COORD_W;
    localparam int AW = gbs_pkg::AREA_W;
    localparam int UW = gbs_pkg::UNION_W;
    localparam int PW = gbs_pkg::PROD_W;

    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [AW-1:0] cand_area_reg;

    logic [SW-1:0] iw_reg, ih_reg;
    logic [AW-1:0] sarea_a_reg, sarea_b_reg;
    logic [AW-1:0] inter_b_reg, inter_c_reg, inter_d_reg;
    logic [UW-1:0] union_reg;
    logic [PW-1:0] prod_reg;

    logic signed [CW:0]   ax_s, ay_s, bx_s, by_s;
    logic signed [CW:0]   ax_end, ay_end, bx_end, by_end;
    logic signed [CW:0]   right_s, left_s, bottom_s, top_s;
    logic signed [CW+1:0] iw_s, ih_s;
    logic [SW-1:0]        bw, bh;
    logic                 overlap;

    always_comb begin
        bw     = stored_box[32 +: SW];
        bh     = stored_box[48 +: SW];
        ax_s   = $signed({cand_x[CW-1], cand_x});
        ay_s   = $signed({cand_y[CW-1], cand_y});
        bx_s   = $signed({stored_box[CW-1], stored_box[0 +: CW]});
        by_s   = $signed({stored_box[16+CW-1], stored_box[16 +: CW]});
        ax_end = ax_s + $signed({2'b00, cand_w});
        ay_end = ay_s + $signed({2'b00, cand_h});
        bx_end = bx_s + $signed({2'b00, bw});
        by_end = by_s + $signed({2'b00, bh});
        right_s  = (ax_end < bx_end) ? ax_end : bx_end;
        left_s   = (ax_s > bx_s) ? ax_s : bx_s;
        bottom_s = (ay_end < by_end) ? ay_end : by_end;
        top_s    = (ay_s > by_s) ? ay_s : by_s;
        iw_s = $signed({right_s[CW], right_s}) - $signed({left_s[CW], left_s});
        ih_s = $signed({bottom_s[CW], bottom_s}) - $signed({top_s[CW], top_s});
        // a positive extent never exceeds the narrower box, so it fits SW bits
        overlap = (iw_s > 0) && (ih_s > 0);
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        cand_area_reg <= cand_w * cand_h;
        // extents and stored area
        iw_reg      <= overlap ? iw_s[SW-1:0] : '0;
        ih_reg      <= overlap ? ih_s[SW-1:0] : '0;
        sarea_a_reg <= bw * bh;
        // intersection area
        inter_b_reg <= iw_reg * ih_reg;
        sarea_b_reg <= sarea_a_reg;
        // union, never negative
        union_reg   <= {1'b0, cand_area_reg} + {1'b0, sarea_b_reg} - {1'b0, inter_b_reg};
        inter_c_reg <= inter_b_reg;
        // threshold scaling
        prod_reg    <= iou_threshold * union_reg;
        inter_d_reg <= inter_c_reg;
    end

    assign status.hit  = v5_reg && ({1'b0, inter_d_reg, 8'h00} > prod_reg);
    assign status.busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;

endmodule

`default_nettype wire
